### hdl/clsrng_pkg.sv
// ----------------------------------------------------------------------------
// clsrng_pkg
// Constants, command bundle and modular helpers shared by the combined
// congruential generator with shuffle table.
// ----------------------------------------------------------------------------
package clsrng_pkg;

    localparam int VAL_W  = 31;
    localparam int PROD_W = 47;
    localparam int M170_W = 39;
    localparam int DATA_W = 64;

    localparam logic [30:0] MOD1     = 31'd2147483563;
    localparam logic [30:0] MOD2     = 31'd2147483399;
    localparam logic [30:0] WRAP     = 31'd2147483562;
    localparam logic [15:0] MUL1     = 16'd40014;
    localparam logic [15:0] MUL2     = 16'd40692;
    localparam logic [7:0]  FOLD1    = 8'd85;
    localparam logic [7:0]  FOLD2    = 8'd249;
    localparam logic [7:0]  FRAC_MUL = 8'd170;

    typedef struct packed {
        logic seed_load;
        logic mul;
        logic red1;
        logic red2;
        logic fill;
        logic slot_upd;
        logic rd;
        logic comb;
        logic frac1;
        logic out_load;
    } t_cmd;

    // p = H*2^31 + L, and 2^31 = m + fold, so p mod m = (H*fold + L) mod m
    function automatic logic [30:0] mod_fold(input logic [46:0] p,
                                             input logic [7:0]  fold,
                                             input logic [30:0] m);
        logic [31:0] s;
        s = ({16'd0, p[46:31]} * {24'd0, fold}) + {1'b0, p[30:0]};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[30:0];
    endfunction

    // floor(y * 2^32 / MOD1) = 2y + floor(170y / MOD1)
    function automatic logic [31:0] frac_of(input logic [30:0] y,
                                            input logic [38:0] m170);
        logic [31:0] t;
        logic [31:0] q;
        t = ({24'd0, m170[38:31]} * 32'd85) + {1'b0, m170[30:0]};
        q = {y, 1'b0} + {24'd0, m170[38:31]};
        if (t >= {1'b0, MOD1}) begin
            q = q + 32'd1;
        end
        return q;
    endfunction

endpackage

### hdl/clsrng_ctrl.sv
// ----------------------------------------------------------------------------
// clsrng_ctrl
// Sequencer: accepts a word, runs seeding when needed, then the draw steps,
// and holds the output valid flag.
// ----------------------------------------------------------------------------
module clsrng_ctrl
    import clsrng_pkg::*;
#(
    parameter  int TABLE_SIZE = 32,
    localparam int IDX_W      = $clog2(TABLE_SIZE),
    localparam int CNT_W      = $clog2(TABLE_SIZE + 8)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_restart,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_fill_idx
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_SMUL,
        S_SRED,
        S_MUL,
        S_RED,
        S_READ,
        S_COMB,
        S_FR1,
        S_FR2
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_seeded, n_seeded;
    logic               r_out_valid, n_out_valid;
    t_cmd               cmd;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_seeded    = r_seeded;
        cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_restart || !r_seeded) ? S_SEED : S_MUL;
                end
            end
            S_SEED: begin
                cmd.seed_load = 1'b1;
                n_cnt         = CNT_W'(TABLE_SIZE + 7);
                n_state       = S_SMUL;
            end
            S_SMUL: begin
                cmd.mul = 1'b1;
                n_state = S_SRED;
            end
            S_SRED: begin
                cmd.red1 = 1'b1;
                cmd.fill = (r_cnt < CNT_W'(TABLE_SIZE));
                if (r_cnt == '0) begin
                    n_seeded = 1'b1;
                    n_state  = S_MUL;
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_SMUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_RED;
            end
            S_RED: begin
                cmd.red1     = 1'b1;
                cmd.red2     = 1'b1;
                cmd.slot_upd = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                cmd.rd  = 1'b1;
                n_state = S_COMB;
            end
            S_COMB: begin
                cmd.comb = 1'b1;
                n_state  = S_FR1;
            end
            S_FR1: begin
                cmd.frac1 = 1'b1;
                n_state   = S_FR2;
            end
            S_FR2: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || cmd.out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
    assign o_fill_idx  = r_cnt[IDX_W-1:0];

endmodule

### hdl/clsrng_dpath.sv
// ----------------------------------------------------------------------------
// clsrng_dpath
// Both generator registers, constant-multiply and fold reduction, the shuffle
// table memory, slot selection and fraction scaling.
// ----------------------------------------------------------------------------
module clsrng_dpath
    import clsrng_pkg::*;
#(
    parameter  int TABLE_SIZE = 32,
    localparam int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [IDX_W-1:0]  i_fill_idx,
    input  logic [VAL_W-1:0]  i_seed,
    output logic [DATA_W-1:0] o_data
);

    localparam int          Q_W      = $clog2(TABLE_SIZE) + 1;
    localparam logic [31:0] SLOT_DIV = 32'(64'd1 + (64'd2147483562 / 64'(TABLE_SIZE)));
    localparam logic [Q_W-1:0] RECIP = Q_W'(64'd2147483648 / 64'(SLOT_DIV));

    logic [VAL_W-1:0]  r_x1, r_x2, r_last, r_tab;
    logic [PROD_W-1:0] r_p1, r_p2;
    logic [Q_W-1:0]    r_qest;
    logic [IDX_W-1:0]  r_slot;
    logic [M170_W-1:0] r_m170;
    logic [DATA_W-1:0] r_out;
    logic [VAL_W-1:0]  mem [TABLE_SIZE];

    logic [VAL_W-1:0]     seed_fix, seed_sub, red1, red2, y;
    logic [VAL_W+Q_W-1:0] qest_prod;
    logic [31:0]          slot_rem, diff;
    logic [Q_W-1:0]       slot_q;

    always_comb begin
        seed_sub = (i_seed >= MOD1) ? (i_seed - MOD1) : i_seed;
        seed_fix = (seed_sub == '0) ? VAL_W'(1) : seed_sub;

        red1 = mod_fold(r_p1, FOLD1, MOD1);
        red2 = mod_fold(r_p2, FOLD2, MOD2);

        qest_prod = {{Q_W{1'b0}}, r_last} * {{VAL_W{1'b0}}, RECIP};

        slot_rem = {1'b0, r_last} - (32'(r_qest) * SLOT_DIV);
        slot_q   = r_qest;
        if (slot_rem >= SLOT_DIV) begin
            slot_q = r_qest + Q_W'(1);
        end
        if (slot_q >= Q_W'(TABLE_SIZE)) begin
            slot_q = Q_W'(TABLE_SIZE - 1);
        end

        diff = {1'b0, r_tab} - {1'b0, r_x2};
        if (diff[31] || diff == '0) begin
            diff = diff + {1'b0, WRAP};
        end
        y = diff[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_x1 <= seed_fix;
            r_x2 <= seed_fix;
        end else begin
            if (i_cmd.red1) begin
                r_x1 <= red1;
            end
            if (i_cmd.red2) begin
                r_x2 <= red2;
            end
        end
        if (i_cmd.mul) begin
            r_p1   <= {16'd0, r_x1} * {31'd0, MUL1};
            r_p2   <= {16'd0, r_x2} * {31'd0, MUL2};
            r_qest <= qest_prod[VAL_W+Q_W-1:VAL_W];
        end
        if (i_cmd.fill) begin
            r_last <= red1;
        end else if (i_cmd.comb) begin
            r_last <= y;
        end
        if (i_cmd.slot_upd) begin
            r_slot <= slot_q[IDX_W-1:0];
        end
        if (i_cmd.frac1) begin
            r_m170 <= {8'd0, r_last} * {31'd0, FRAC_MUL};
        end
        if (i_cmd.out_load) begin
            r_out <= {1'b0, frac_of(r_last, r_m170), r_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            mem[i_fill_idx] <= red1;
        end else if (i_cmd.comb) begin
            mem[r_slot] <= r_x1;
        end
        if (i_cmd.rd) begin
            r_tab <= mem[r_slot];
        end
    end

    assign o_data = r_out;

endmodule

### hdl/combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Plain draw: once the word is taken, S_MUL, S_RED, S_READ, S_COMB, S_FR1 and
// S_FR2 run in order; no new word is taken until the result is loaded.
// Seeding (restart, or first draw after reset) adds S_SEED and TABLE_SIZE+8 generator
// steps, each a multiply and a fold reduction; the table fills through one write port.
// Reset (synchronous, active low) clears control, output valid and the
// seeded flag, and sets the seed register to 1.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng
    import clsrng_pkg::*;
#(
    parameter int TABLE_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [30:0] random_value, [62:31] uniform_fraction
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic [VAL_W-1:0]  r_seed;
    t_cmd              cmd;
    logic [IDX_W-1:0]  fill_idx;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {1'b0, r_seed} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= VAL_W'(1);
        end else if (cfg_wr) begin
            r_seed <= pwdata[VAL_W-1:0];
        end
    end

    clsrng_ctrl #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .i_restart   (s_tdata[0]),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_cmd       (cmd),
        .o_fill_idx  (fill_idx)
    );

    clsrng_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_fill_idx (fill_idx),
        .i_seed     (r_seed),
        .o_data     (m_tdata)
    );

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word taken while a draw is in progress");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[30:0] != 31'd0) && (m_tdata[30:0] <= WRAP))
        else $error("random value out of range");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ({1'b0, m_tdata[62:31]} >= {1'b0, m_tdata[30:0], 1'b0})
                     && (m_tdata[63] == 1'b0))
        else $error("fraction inconsistent with value");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.seed_load, cmd.mul, cmd.red1, cmd.rd, cmd.comb,
                  cmd.frac1, cmd.out_load}))
        else $error("overlapping datapath commands");

endmodule
